// ===== sv/sphdp_pkg.sv =====
package sphdp_pkg;

    localparam int POS_W    = 32;
    localparam int MAG_W    = POS_W + 1;
    localparam int SCALE_W  = 24;
    localparam int RSQ_W    = 24;
    localparam int COEFF_W  = 32;
    localparam int REST_W   = 32;
    localparam int STIFF_W  = 16;
    localparam int MASS_W   = 16;
    localparam int ACC_W    = 64;
    localparam int SUMSQ_W  = 50;
    localparam int DENS_W   = 32;
    localparam int PRES_W   = 32;
    localparam int INV_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // shared multiplier: signed 34 x 33
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // reciprocal: 2^32 / density, one quotient bit per cycle
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = 6;
    localparam int QUO_W     = DIV_STEPS;

    localparam logic [PRES_W-1:0] PRES_MAX = {1'b0, {(PRES_W-1){1'b1}}};
    localparam logic [PRES_W-1:0] PRES_MIN = {1'b1, {(PRES_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LENGTH_SCALE   = 3'd0,
        REG_RADIUS_SQUARED = 3'd1,
        REG_KERNEL_COEFF   = 3'd2,
        REG_REST_DENSITY   = 3'd3,
        REG_STIFFNESS      = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MUL_NONE = 4'd0,
        MUL_DX   = 4'd1,
        MUL_DY   = 4'd2,
        MUL_DZ   = 4'd3,
        MUL_SQX  = 4'd4,
        MUL_SQY  = 4'd5,
        MUL_SQZ  = 4'd6,
        MUL_C2   = 4'd7,
        MUL_C3   = 4'd8,
        MUL_TERM = 4'd9,
        MUL_DHI  = 4'd10,
        MUL_DLO  = 4'd11,
        MUL_PRES = 4'd12
    } mul_op_t;

    typedef enum logic [20:0] {
        S_IDLE = 21'd1 << 0,
        S_DX   = 21'd1 << 1,
        S_DY   = 21'd1 << 2,
        S_DZ   = 21'd1 << 3,
        S_SQX  = 21'd1 << 4,
        S_SQY  = 21'd1 << 5,
        S_SQZ  = 21'd1 << 6,
        S_SUM  = 21'd1 << 7,
        S_CMP  = 21'd1 << 8,
        S_C2   = 21'd1 << 9,
        S_C3   = 21'd1 << 10,
        S_TERM = 21'd1 << 11,
        S_ACC  = 21'd1 << 12,
        S_DHI  = 21'd1 << 13,
        S_DLO  = 21'd1 << 14,
        S_DSUM = 21'd1 << 15,
        S_DSAT = 21'd1 << 16,
        S_PRES = 21'd1 << 17,
        S_PCAP = 21'd1 << 18,
        S_DIV  = 21'd1 << 19,
        S_OUT  = 21'd1 << 20
    } state_t;

    typedef struct packed {
        logic    load_in;
        mul_op_t mul_op;
        logic    cap_dx;
        logic    cap_dy;
        logic    cap_dz;
        logic    sum_init;
        logic    sum_add;
        logic    cmp;
        logic    acc_add;
        logic    acc_clr;
        logic    s_init;
        logic    s_add;
        logic    dens_cap;
        logic    p_cap;
        logic    div_start;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ===== sv/sphdp_div.sv =====
module sphdp_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [sphdp_pkg::DENS_W-1:0]       divisor,
    output logic                               done,
    output logic [sphdp_pkg::QUO_W-1:0]        quotient
);
    import sphdp_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DENS_W-1:0]    div_reg, div_next;
    logic [DENS_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;

    logic              nbit;
    logic [DENS_W:0]   shifted;
    logic [DENS_W:0]   trial;
    logic              ge;

    // numerator is 2^32: only its top bit is set
    assign nbit    = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign shifted = {rem_reg, nbit};
    assign ge      = (shifted >= {1'b0, div_reg});
    assign trial   = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            div_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial[DENS_W-1:0] : shifted[DENS_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/sphdp_datapath.sv =====
module sphdp_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sphdp_pkg::cmd_t                        cmd,
    output sphdp_pkg::status_t                     status,
    input  logic                                   cfg_we,
    input  logic [sphdp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sphdp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [sphdp_pkg::POS_W-1:0]     self_x,
    input  logic signed [sphdp_pkg::POS_W-1:0]     self_y,
    input  logic signed [sphdp_pkg::POS_W-1:0]     self_z,
    input  logic signed [sphdp_pkg::POS_W-1:0]     other_x,
    input  logic signed [sphdp_pkg::POS_W-1:0]     other_y,
    input  logic signed [sphdp_pkg::POS_W-1:0]     other_z,
    input  logic [sphdp_pkg::MASS_W-1:0]           other_mass,
    input  logic                                   last,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [sphdp_pkg::DENS_W-1:0]           density,
    output logic signed [sphdp_pkg::PRES_W-1:0]    pressure,
    output logic [sphdp_pkg::INV_W-1:0]            inv_density,
    output logic                                   zero_density
);
    import sphdp_pkg::*;

    // configuration
    logic [SCALE_W-1:0] scale_reg;
    logic [RSQ_W-1:0]   rsq_reg;
    logic [COEFF_W-1:0] coeff_reg;
    logic [REST_W-1:0]  rest_reg;
    logic [STIFF_W-1:0] stiff_reg;

    // per-request working registers
    logic [MAG_W-1:0]   magx_reg, magy_reg, magz_reg;
    logic [MASS_W-1:0]  mass_reg;
    logic               last_reg;
    logic [SCALE_W-1:0] dx_reg, dy_reg, dz_reg;
    logic               oor_reg;
    logic [SUMSQ_W-1:0] sumsq_reg;
    logic               inside_reg;
    logic [RSQ_W-1:0]   c_reg;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W:0]     s_reg;
    logic [DENS_W-1:0]  dens_reg;
    logic [PRES_W-1:0]  pres_reg;

    logic signed [PROD_W-1:0] prod_reg;

    logic                     out_valid_reg;
    logic [DENS_W-1:0]        density_reg;
    logic [PRES_W-1:0]        pressure_reg;
    logic [INV_W-1:0]         inv_reg;
    logic                     zero_reg;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_next;

    logic [MAG_W-1:0]   diffx, diffy, diffz;
    logic [MAG_W-1:0]   absx, absy, absz;
    logic [SUMSQ_W-RSQ_W-1:0] d2;
    logic [ACC_W:0]     acc_sum;
    logic [ACC_W:0]     s_sum;
    logic [MUL_A_W-1:0] pdiff;
    logic [DENS_W-1:0]  dens_sat;
    logic signed [PROD_W-1:0] pshift;
    logic [PROD_W-PRES_W:0]   pres_hi;
    logic [PRES_W-1:0]  pres_sat;

    logic               div_done;
    logic [QUO_W-1:0]   quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= '0;
            rsq_reg   <= '0;
            coeff_reg <= '0;
            rest_reg  <= '0;
            stiff_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LENGTH_SCALE:   scale_reg <= cfg_data[SCALE_W-1:0];
                REG_RADIUS_SQUARED: rsq_reg   <= cfg_data[RSQ_W-1:0];
                REG_KERNEL_COEFF:   coeff_reg <= cfg_data[COEFF_W-1:0];
                REG_REST_DENSITY:   rest_reg  <= cfg_data[REST_W-1:0];
                REG_STIFFNESS:      stiff_reg <= cfg_data[STIFF_W-1:0];
                default:            ;
            endcase
        end
    end

    // 33-bit differences; magnitude of -2^32 still fits unsigned
    assign diffx = {self_x[POS_W-1], self_x} - {other_x[POS_W-1], other_x};
    assign diffy = {self_y[POS_W-1], self_y} - {other_y[POS_W-1], other_y};
    assign diffz = {self_z[POS_W-1], self_z} - {other_z[POS_W-1], other_z};
    assign absx  = diffx[MAG_W-1] ? (~diffx + 1'b1) : diffx;
    assign absy  = diffy[MAG_W-1] ? (~diffy + 1'b1) : diffy;
    assign absz  = diffz[MAG_W-1] ? (~diffz + 1'b1) : diffz;

    assign pdiff = {2'b00, dens_reg} - {2'b00, rest_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            MUL_DX:
            begin
                mul_a = {1'b0, magx_reg};
                mul_b = {9'b0, scale_reg};
            end
            MUL_DY:
            begin
                mul_a = {1'b0, magy_reg};
                mul_b = {9'b0, scale_reg};
            end
            MUL_DZ:
            begin
                mul_a = {1'b0, magz_reg};
                mul_b = {9'b0, scale_reg};
            end
            MUL_SQX:
            begin
                mul_a = {10'b0, dx_reg};
                mul_b = {9'b0, dx_reg};
            end
            MUL_SQY:
            begin
                mul_a = {10'b0, dy_reg};
                mul_b = {9'b0, dy_reg};
            end
            MUL_SQZ:
            begin
                mul_a = {10'b0, dz_reg};
                mul_b = {9'b0, dz_reg};
            end
            MUL_C2:
            begin
                mul_a = {10'b0, c_reg};
                mul_b = {9'b0, c_reg};
            end
            MUL_C3:
            begin
                mul_a = {10'b0, prod_reg[47:24]};
                mul_b = {9'b0, c_reg};
            end
            MUL_TERM:
            begin
                mul_a = {10'b0, prod_reg[47:24]};
                mul_b = {17'b0, mass_reg};
            end
            MUL_DHI:
            begin
                mul_a = {2'b0, acc_reg[ACC_W-1:32]};
                mul_b = {1'b0, coeff_reg};
            end
            MUL_DLO:
            begin
                mul_a = {2'b0, acc_reg[31:0]};
                mul_b = {1'b0, coeff_reg};
            end
            MUL_PRES:
            begin
                mul_a = pdiff;
                mul_b = {17'b0, stiff_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign d2      = sumsq_reg[SUMSQ_W-1:RSQ_W];
    assign acc_sum = {1'b0, acc_reg} + {25'b0, prod_reg[39:0]};
    assign s_sum   = s_reg + {33'b0, prod_reg[63:32]};

    // s >= 2^36 saturates, including the carry out of the 64-bit add
    assign dens_sat = (|s_reg[ACC_W:36]) ? '1 : s_reg[35:4];

    assign pshift  = prod_reg >>> 8;
    assign pres_hi = pshift[PROD_W-1:PRES_W-1];
    assign pres_sat = ((pres_hi == '0) || (pres_hi == '1)) ? pshift[PRES_W-1:0]
                    : (pshift[PROD_W-1] ? PRES_MIN : PRES_MAX);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clr)
            acc_next = '0;
        else if (cmd.acc_add && inside_reg)
            acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load_in)
        begin
            magx_reg <= absx;
            magy_reg <= absy;
            magz_reg <= absz;
            mass_reg <= other_mass;
            last_reg <= last;
        end
        if (cmd.cap_dx)
        begin
            dx_reg  <= prod_reg[39:16];
            oor_reg <= |prod_reg[PROD_W-1:40];
        end
        if (cmd.cap_dy)
        begin
            dy_reg  <= prod_reg[39:16];
            oor_reg <= oor_reg | (|prod_reg[PROD_W-1:40]);
        end
        if (cmd.cap_dz)
        begin
            dz_reg  <= prod_reg[39:16];
            oor_reg <= oor_reg | (|prod_reg[PROD_W-1:40]);
        end
        if (cmd.sum_init)
            sumsq_reg <= {2'b0, prod_reg[47:0]};
        else if (cmd.sum_add)
            sumsq_reg <= sumsq_reg + {2'b0, prod_reg[47:0]};
        if (cmd.cmp)
        begin
            inside_reg <= !oor_reg && ({2'b0, rsq_reg} > d2);
            c_reg      <= rsq_reg - d2[RSQ_W-1:0];
        end
        if (cmd.s_init)
            s_reg <= {1'b0, prod_reg[ACC_W-1:0]};
        else if (cmd.s_add)
            s_reg <= s_sum;
        if (cmd.dens_cap)
            dens_reg <= dens_sat;
        if (cmd.p_cap)
            pres_reg <= pres_sat;
    end

    sphdp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (dens_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // result register; lets a new request in while this one waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            density_reg  <= dens_reg;
            pressure_reg <= pres_reg;
            inv_reg      <= (quotient[QUO_W-1] || dens_reg == '0) ? '1
                                                                  : quotient[INV_W-1:0];
            zero_reg     <= (dens_reg == '0);
        end
    end

    assign status.last     = last_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign density      = density_reg;
    assign pressure     = pressure_reg;
    assign inv_density  = inv_reg;
    assign zero_density = zero_reg;

endmodule

// ===== sv/sphdp_ctrl.sv =====
module sphdp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sphdp_pkg::status_t    status,
    output sphdp_pkg::cmd_t       cmd
);
    import sphdp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DX;
                end
            end
            S_DX:
            begin
                cmd.mul_op = MUL_DX;
                state_next = S_DY;
            end
            S_DY:
            begin
                cmd.mul_op = MUL_DY;
                cmd.cap_dx = 1'b1;
                state_next = S_DZ;
            end
            S_DZ:
            begin
                cmd.mul_op = MUL_DZ;
                cmd.cap_dy = 1'b1;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                cmd.mul_op = MUL_SQX;
                cmd.cap_dz = 1'b1;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.mul_op   = MUL_SQY;
                cmd.sum_init = 1'b1;
                state_next   = S_SQZ;
            end
            S_SQZ:
            begin
                cmd.mul_op  = MUL_SQZ;
                cmd.sum_add = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_add = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_C2;
            end
            S_C2:
            begin
                cmd.mul_op = MUL_C2;
                state_next = S_C3;
            end
            S_C3:
            begin
                cmd.mul_op = MUL_C3;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                cmd.mul_op = MUL_TERM;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = status.last ? S_DHI : S_IDLE;
            end
            S_DHI:
            begin
                cmd.mul_op = MUL_DHI;
                state_next = S_DLO;
            end
            S_DLO:
            begin
                cmd.mul_op = MUL_DLO;
                cmd.s_init = 1'b1;
                state_next = S_DSUM;
            end
            S_DSUM:
            begin
                cmd.s_add  = 1'b1;
                state_next = S_DSAT;
            end
            S_DSAT:
            begin
                cmd.dens_cap = 1'b1;
                state_next   = S_PRES;
            end
            S_PRES:
            begin
                cmd.mul_op    = MUL_PRES;
                cmd.div_start = 1'b1;
                state_next    = S_PCAP;
            end
            S_PCAP:
            begin
                cmd.p_cap  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.acc_clr  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== sv/sph_density_pressure_top.sv =====
// Sequence: a neighbor request uses one shared multiplier for the
//   scale, square, cube and mass products in turn; the request flagged last
//   then also runs the one-bit-per-cycle reciprocal divider.
// Throughput: one result per particle; a new request is taken only in the idle state.
// Reset (rst_n, async, active low): configuration registers cleared to zero, accumulator empty,
//   no result pending.
module sph_density_pressure_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [sphdp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sphdp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [sphdp_pkg::POS_W-1:0]     self_x,
    input  logic signed [sphdp_pkg::POS_W-1:0]     self_y,
    input  logic signed [sphdp_pkg::POS_W-1:0]     self_z,
    input  logic signed [sphdp_pkg::POS_W-1:0]     other_x,
    input  logic signed [sphdp_pkg::POS_W-1:0]     other_y,
    input  logic signed [sphdp_pkg::POS_W-1:0]     other_z,
    input  logic [sphdp_pkg::MASS_W-1:0]           other_mass,
    input  logic                                   last,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [sphdp_pkg::DENS_W-1:0]           density,
    output logic signed [sphdp_pkg::PRES_W-1:0]    pressure,
    output logic [sphdp_pkg::INV_W-1:0]            inv_density,
    output logic                                   zero_density
);
    import sphdp_pkg::*;

    cmd_t    cmd;
    status_t status;

    sphdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sphdp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .self_x       (self_x),
        .self_y       (self_y),
        .self_z       (self_z),
        .other_x      (other_x),
        .other_y      (other_y),
        .other_z      (other_z),
        .other_mass   (other_mass),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .density      (density),
        .pressure     (pressure),
        .inv_density  (inv_density),
        .zero_density (zero_density)
    );

endmodule

// ===== dv/sph_density_pressure_checker.sv =====
`timescale 1ns / 1ps

module sph_density_pressure_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [sphdp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sphdp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic signed [sphdp_pkg::POS_W-1:0]     self_x,
    input  logic signed [sphdp_pkg::POS_W-1:0]     self_y,
    input  logic signed [sphdp_pkg::POS_W-1:0]     self_z,
    input  logic signed [sphdp_pkg::POS_W-1:0]     other_x,
    input  logic signed [sphdp_pkg::POS_W-1:0]     other_y,
    input  logic signed [sphdp_pkg::POS_W-1:0]     other_z,
    input  logic [sphdp_pkg::MASS_W-1:0]           other_mass,
    input  logic                                   last,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic [sphdp_pkg::DENS_W-1:0]           density,
    input  logic signed [sphdp_pkg::PRES_W-1:0]    pressure,
    input  logic [sphdp_pkg::INV_W-1:0]            inv_density,
    input  logic                                   zero_density,
    output int unsigned                            mismatches,
    output int unsigned                            awaiting,
    output int unsigned                            results_seen
);
    import sphdp_pkg::*;

    typedef struct packed {
        logic [DENS_W-1:0] density;
        logic [PRES_W-1:0] pressure;
        logic [INV_W-1:0]  inv_density;
        logic              zero_density;
    } particle_result_t;

    localparam logic [63:0] UNIT_DIST = 64'd1 << 24;
    localparam int unsigned PRINT_LIMIT = 50;

    logic [SCALE_W-1:0] scale_r;
    logic [RSQ_W-1:0]   rsq_r;
    logic [COEFF_W-1:0] coeff_r;
    logic [REST_W-1:0]  rest_r;
    logic [STIFF_W-1:0] stiff_r;
    logic [ACC_W-1:0]   mass_sum;
    particle_result_t   density_q[$];
    particle_result_t   want;
    logic [64:0]        sum_wide;
    int unsigned        fail_tally;
    int unsigned        seen_tally;

    // scaled per-axis distance, Q.24
    function automatic logic [63:0] scaled_gap(input logic signed [POS_W-1:0] a,
                                               input logic signed [POS_W-1:0] b,
                                               input logic [SCALE_W-1:0] scale);
        logic signed [63:0] d;
        logic [63:0]        m;
        d = $signed({{32{a[POS_W-1]}}, a}) - $signed({{32{b[POS_W-1]}}, b});
        m = (d < 0) ? -d : d;
        return (m * {40'd0, scale}) >> 16;
    endfunction

    // mass * (h2 - d2)^3 for one neighbor, zero when outside
    function automatic logic [63:0] pair_weight(input logic [RSQ_W-1:0] rsq,
                                                input logic [SCALE_W-1:0] scale);
        logic [63:0] dx, dy, dz, d2, c, c2, c3;
        dx = scaled_gap(self_x, other_x, scale);
        dy = scaled_gap(self_y, other_y, scale);
        dz = scaled_gap(self_z, other_z, scale);
        if (dx >= UNIT_DIST || dy >= UNIT_DIST || dz >= UNIT_DIST)
            return 64'd0;
        d2 = (dx * dx + dy * dy + dz * dz) >> 24;
        if ({40'd0, rsq} <= d2)
            return 64'd0;
        c  = {40'd0, rsq} - d2;
        c2 = (c * c) >> 24;
        c3 = (c2 * c) >> 24;
        return {48'd0, other_mass} * c3;
    endfunction

    function automatic particle_result_t close_particle(input logic [ACC_W-1:0] sum);
        particle_result_t   r;
        logic [127:0]       prod;
        logic [DENS_W-1:0]  dens;
        logic signed [63:0] diff, p, pr;
        prod = ({64'd0, sum} * {96'd0, coeff_r}) >> 36;
        dens = (prod > 128'hFFFF_FFFF) ? '1 : prod[DENS_W-1:0];
        diff = $signed({32'd0, dens}) - $signed({32'd0, rest_r});
        p    = diff * $signed({48'd0, stiff_r});
        pr   = p >>> 8;
        if (pr > 64'sd2147483647)
            pr = 64'sd2147483647;
        if (pr < -64'sd2147483648)
            pr = -64'sd2147483648;
        r.density      = dens;
        r.pressure     = pr[PRES_W-1:0];
        r.zero_density = (dens == '0);
        // one LSB would give 2^32, which does not fit either
        if (dens <= 32'd1)
            r.inv_density = '1;
        else
            r.inv_density = 32'(64'h1_0000_0000 / {32'd0, dens});
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
        fail_tally++;
        if (fail_tally <= PRINT_LIMIT)
            $display("%0t: %0s mismatch on result %0d: got %h, expected %h",
                     $realtime, what, seen_tally, got, exp_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_r  = '0;
            rsq_r    = '0;
            coeff_r  = '0;
            rest_r   = '0;
            stiff_r  = '0;
            mass_sum = '0;
            density_q.delete();
            fail_tally = 0;
            seen_tally = 0;
            mismatches   <= 0;
            awaiting     <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen_tally++;
                if (density_q.size() == 0)
                    report("unrequested result, density", density, '0);
                else
                begin
                    want = density_q.pop_front();
                    if (density !== want.density)
                        report("density", density, want.density);
                    if (pressure !== want.pressure)
                        report("pressure", pressure, want.pressure);
                    if (inv_density !== want.inv_density)
                        report("inv_density", inv_density, want.inv_density);
                    if (zero_density !== want.zero_density)
                        report("zero_density", {31'd0, zero_density}, {31'd0, want.zero_density});
                end
            end

            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_LENGTH_SCALE:   scale_r = cfg_data[SCALE_W-1:0];
                    REG_RADIUS_SQUARED: rsq_r   = cfg_data[RSQ_W-1:0];
                    REG_KERNEL_COEFF:   coeff_r = cfg_data[COEFF_W-1:0];
                    REG_REST_DENSITY:   rest_r  = cfg_data[REST_W-1:0];
                    REG_STIFFNESS:      stiff_r = cfg_data[STIFF_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                sum_wide = {1'b0, mass_sum} + {1'b0, pair_weight(rsq_r, scale_r)};
                mass_sum = sum_wide[64] ? '1 : sum_wide[ACC_W-1:0];
                if (last)
                begin
                    density_q = {density_q, close_particle(mass_sum)};
                    mass_sum = '0;
                end
            end

            mismatches   <= fail_tally;
            awaiting     <= density_q.size();
            results_seen <= seen_tally;
        end
    end

endmodule

// ===== dv/sph_density_pressure_top_tb.sv =====
`timescale 1ns / 1ps

module sph_density_pressure_top_tb;
    import sphdp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX  = 3'd7;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_ITEMS   = 650;
    localparam int QUIET_FROM     = 560;
    localparam int PHASE_ITEMS    = 110;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    logic                      clk;
    logic                      rst_n      = 1'b0;
    logic                      cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index  = '0;
    logic [CFG_DATA_W-1:0]     cfg_data   = '0;
    logic                      in_valid   = 1'b0;
    logic                      in_stall;
    logic signed [POS_W-1:0]   self_x     = '0;
    logic signed [POS_W-1:0]   self_y     = '0;
    logic signed [POS_W-1:0]   self_z     = '0;
    logic signed [POS_W-1:0]   other_x    = '0;
    logic signed [POS_W-1:0]   other_y    = '0;
    logic signed [POS_W-1:0]   other_z    = '0;
    logic [MASS_W-1:0]         other_mass = '0;
    logic                      last       = 1'b0;
    logic                      out_valid;
    logic                      out_stall  = 1'b0;
    logic [DENS_W-1:0]         density;
    logic signed [PRES_W-1:0]  pressure;
    logic [INV_W-1:0]          inv_density;
    logic                      zero_density;

    int unsigned mismatches;
    int unsigned awaiting;
    int unsigned results_seen;

    logic        quiet = 1'b0;
    logic [SCALE_W-1:0] cur_scale = '0;
    int          items_sent;
    int          random_sent;
    int          settings_applied;
    int          stall_left;

    sph_density_pressure_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .self_x       (self_x),
        .self_y       (self_y),
        .self_z       (self_z),
        .other_x      (other_x),
        .other_y      (other_y),
        .other_z      (other_z),
        .other_mass   (other_mass),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .density      (density),
        .pressure     (pressure),
        .inv_density  (inv_density),
        .zero_density (zero_density)
    );

    sph_density_pressure_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .self_x       (self_x),
        .self_y       (self_y),
        .self_z       (self_z),
        .other_x      (other_x),
        .other_y      (other_y),
        .other_z      (other_z),
        .other_mass   (other_mass),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .density      (density),
        .pressure     (pressure),
        .inv_density  (inv_density),
        .zero_density (zero_density),
        .mismatches   (mismatches),
        .awaiting     (awaiting),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("sph_density_pressure_top_tb failed");
        $finish;
    end

    // result side back-pressure in short bursts
    always @(posedge clk)
    begin
        if (quiet || !rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 4) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_LENGTH_SCALE)
            cur_scale = data[SCALE_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // upper bits above each register's width are junk and must be dropped
    task automatic apply_config(input logic [SCALE_W-1:0] scale, input logic [RSQ_W-1:0] rsq,
                                input logic [COEFF_W-1:0] coeff, input logic [REST_W-1:0] rest,
                                input logic [STIFF_W-1:0] stiff);
        write_reg(REG_LENGTH_SCALE, {8'($urandom), scale});
        write_reg(REG_RADIUS_SQUARED, {8'($urandom), rsq});
        write_reg(REG_KERNEL_COEFF, coeff);
        write_reg(REG_REST_DENSITY, rest);
        write_reg(REG_STIFFNESS, {16'($urandom), stiff});
        settings_applied++;
    endtask

    task automatic send(input logic signed [POS_W-1:0] sx, input logic signed [POS_W-1:0] sy,
                        input logic signed [POS_W-1:0] sz, input logic signed [POS_W-1:0] ox,
                        input logic signed [POS_W-1:0] oy, input logic signed [POS_W-1:0] oz,
                        input logic [MASS_W-1:0] mass, input logic lst);
        in_valid   <= 1'b1;
        self_x     <= sx;
        self_y     <= sy;
        self_z     <= sz;
        other_x    <= ox;
        other_y    <= oy;
        other_z    <= oz;
        other_mass <= mass;
        last       <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // offset that lands near the smoothing range for the current scale
    function automatic logic signed [POS_W-1:0] near_offset();
        longint reach, span;
        reach = (cur_scale == 0) ? (64'sd1 << 30) : ((64'sd1 << 40) / longint'(cur_scale));
        if (reach > (64'sd1 << 30))
            reach = 64'sd1 << 30;
        span = ($urandom_range(0, 1) == 1) ? reach / 4 : reach * 5 / 4;
        return 32'(longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    task automatic send_particle(input int n);
        logic signed [POS_W-1:0] sx, sy, sz;
        logic [MASS_W-1:0]       mass;
        sx = $signed($urandom) >>> 2;
        sy = $signed($urandom) >>> 2;
        sz = $signed($urandom) >>> 2;
        for (int k = 0; k < n; k++)
        begin
            mass = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(16'h1000 + $urandom_range(0, 4095));
            send(sx, sy, sz, sx - near_offset(), sy - near_offset(), sz - near_offset(),
                 mass, k == n - 1);
        end
    endtask

    task automatic random_config();
        logic [SCALE_W-1:0] scale;
        logic [RSQ_W-1:0]   rsq;
        logic [COEFF_W-1:0] coeff;
        case ($urandom_range(0, 5))
            0:       scale = '0;
            1:       scale = '1;
            default: scale = 24'($urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 12));
        endcase
        rsq   = ($urandom_range(0, 5) == 0) ? '1 : 24'($urandom >> $urandom_range(8, 12));
        coeff = ($urandom_range(0, 7) == 0) ? '1 : ($urandom >> $urandom_range(4, 20));
        apply_config(scale, rsq, coeff, $urandom >> $urandom_range(0, 24),
                     16'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        int phase;
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: radius zero, nothing can contribute
        send(0, 0, 0, 0, 0, 0, '0, 1'b0);
        send(POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN, '1, 1'b1);
        settle();

        // zero scale puts every neighbor at the center; coeff picked for a one-LSB density
        write_reg(REG_UNMAPPED, '1);
        apply_config('0, '1, 32'h0000_1001, '0, 16'h0100);
        send(0, 0, 0, 0, 0, 0, 16'd1, 1'b1);
        settle();
        // contribution that truncates to zero density
        write_reg(REG_KERNEL_COEFF, 32'h0000_1000);
        send(0, 0, 0, 0, 0, 0, 16'd1, 1'b1);
        settle();
        write_reg(REG_TOP_IDX, 32'h0000_1001);
        send(0, 0, 0, 0, 0, 0, 16'd1, 1'b1);
        settle();

        // all registers at their maximum but rest density, which is zero
        apply_config('1, '1, '1, '0, '1);
        send(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, '1, 1'b0);
        send(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN, '1, 1'b0);
        send(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, '1, 1'b0);
        send(32'sd65536, 0, 0, 0, 0, 0, '0, 1'b0);
        send(0, 0, 0, 0, 32'sd65537, 0, '1, 1'b0);
        send(32'sd65536, 32'sd65536, 32'sd65536, 0, 0, 0, '1, 1'b0);
        send(0, 0, 0, 0, 0, 0, '1, 1'b1);
        settle();

        // negative pressure saturation, density zero
        write_reg(REG_REST_DENSITY, '1);
        write_reg(REG_KERNEL_COEFF, '0);
        send(0, 0, 0, 0, 0, 0, '1, 1'b1);
        settle();

        apply_config(24'h02_0000, 24'h40_0000, 32'h0010_0000, 32'h0001_0000, 16'h0080);
        send_particle(5);
        settle();

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            random_config();
            for (int k = 0; k < PHASE_ITEMS && random_sent < RANDOM_ITEMS; )
            begin
                if (random_sent >= QUIET_FROM)
                    quiet <= 1'b1;
                if (phase == 2 && k >= PHASE_ITEMS / 2 && k < PHASE_ITEMS / 2 + 8)
                begin
                    hold_until_drained();
                    k = PHASE_ITEMS / 2 + 8;
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    send(32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                         32'($urandom), 32'($urandom), 16'($urandom),
                         $urandom_range(0, 7) == 0);
                    n = 1;
                end
                else
                begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
                    send_particle(n);
                end
                k += n;
                random_sent += n;
            end
            phase++;
        end

        settle();
        $display("%0d requests sent under %0d register settings, %0d particle results checked",
                 items_sent, settings_applied, results_seen);
        $display("included zero, one-LSB and saturated densities, out-of-range axes, idle bursts");
        if (mismatches == 0 && awaiting == 0)
            $display("sph_density_pressure_top_tb passed");
        else
            $display("sph_density_pressure_top_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sphdp_pkg.sv
sv/sphdp_div.sv
sv/sphdp_datapath.sv
sv/sphdp_ctrl.sv
sv/sph_density_pressure_top.sv
dv/sph_density_pressure_checker.sv
dv/sph_density_pressure_top_tb.sv
